// ===== rtl/rcfd_pkg.sv =====
// Shared types, codes and constants of the remote-control frame decoder.
package rcfd_pkg;

   // Frame geometry and burst limit
   localparam int FRAME_BYTES     = 18;
   localparam int BURST_MAX       = 36;
   localparam int COUNT_W         = 6;
   localparam int STORE_IDX_W     = 5;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Request codes carried in req_type
   localparam logic [1:0] REQ_BYTE = 2'd0;
   localparam logic [1:0] REQ_IDLE = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_STICK_CENTER  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_COUNT  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFLINE_LIMIT = 2'd3;

   // Register reset values
   localparam logic [10:0] STICK_CENTER_RST  = 11'd1024;
   localparam logic [7:0]  DEADBAND_RST      = 8'd8;
   localparam logic [3:0]  SETTLE_COUNT_RST  = 4'd10;
   localparam logic [3:0]  OFFLINE_LIMIT_RST = 4'd10;

   // Status bit positions
   localparam int ST_ACCEPTED = 0;
   localparam int ST_CENTRED  = 1;
   localparam int ST_OFFLINE  = 2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [10:0]        chan_right_h;
      logic [10:0]        chan_right_v;
      logic [10:0]        chan_left_h;
      logic [10:0]        chan_left_v;
      logic [3:0]         switches;
      logic signed [15:0] mouse_dx;
      logic signed [15:0] mouse_dy;
      logic signed [15:0] mouse_dz;
      logic [15:0]        mouse_buttons;
      logic [15:0]        key_bits;
      logic [15:0]        wheel;
   } rsp_payload_type;

   // Classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_BYTE,
      OP_IDLE,
      OP_TICK,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

   // One queue slot as seen on either side of the queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_slot_type;

endpackage

// ===== rtl/rc_receiver_frame_decoder_unit.sv =====
// Remote-control frame decoder: 18-byte receiver frames to channel, mouse and key fields.
// Path: a request is written into a command queue slot, then taken by the back end into its response register.
// Throughput: one transaction per cycle while the queue is not full; the command queue holds QUEUE_DEPTH entries,
// and the back end takes one command a cycle whenever its response register is free.
// Reset is synchronous, active high: queue, state and flags clear, registers take defaults.
// The frame store needs no clearing; a frame is decoded only after all its bytes land.
module rc_receiver_frame_decoder_unit #(
   parameter int QUEUE_DEPTH = rcfd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rcfd_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rcfd_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_we,
   input  logic [rcfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rcfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rcfd_pkg::*;

   cmd_slot_type push;
   cmd_slot_type head;
   logic         queue_full;
   logic         pop;

   rcfd_front u_front (
      .req_payload (req_payload),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .queue_full  (queue_full),
      .push        (push)
   );

   rcfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   rcfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/rcfd_front.sv =====
// Front end: takes request transactions and classifies them into commands.
module rcfd_front (
   input  rcfd_pkg::req_payload_type req_payload,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      queue_full,
   output rcfd_pkg::cmd_slot_type    push
);
   import rcfd_pkg::*;

   // Stall only on a full queue, never on valid
   assign req_stall = queue_full;

   // Classify the request code
   always_comb begin
      push.valid    = req_valid && !queue_full;
      push.cmd.data = req_payload.rx_byte;
      unique case (req_payload.req_type)
         REQ_BYTE: push.cmd.op = OP_BYTE;
         REQ_IDLE: push.cmd.op = OP_IDLE;
         REQ_TICK: push.cmd.op = OP_TICK;
         default:  push.cmd.op = OP_NONE;
      endcase
   end

endmodule

// ===== rtl/rcfd_queue.sv =====
// Short command queue between front and back.
module rcfd_queue #(
   parameter int DEPTH = rcfd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rcfd_pkg::cmd_slot_type push,
   output logic                   full,
   output rcfd_pkg::cmd_slot_type head,
   input  logic                   pop
);
   import rcfd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_pop;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
      if (ptr == PW'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + PW'(1);
   endfunction

   assign full       = (count_ff == CW'(DEPTH));
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push.valid ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage, no reset needed
   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ===== rtl/rcfd_back.sv =====
// Back end: frame assembly, decode, centring and offline tracking, response register.
module rcfd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  rcfd_pkg::cmd_slot_type              head,
   output logic                                pop,
   input  logic                                csr_we,
   input  logic [rcfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rcfd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rcfd_pkg::rsp_payload_type           rsp_payload
);
   import rcfd_pkg::*;

   // Configuration registers
   logic [10:0] stick_center_ff;
   logic [7:0]  deadband_ff;
   logic [3:0]  settle_count_ff;
   logic [3:0]  offline_limit_ff;

   // Block state
   logic [7:0]         store_ff [FRAME_BYTES];
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [10:0]        raw_ff [4];
   logic [10:0]        raw_in [4];
   logic [10:0]        shown_ff [4];
   logic [10:0]        shown_in [4];
   logic [3:0]         switch_ff, switch_in;
   logic [15:0]        word_ff [6];
   logic [15:0]        word_in [6];
   logic [3:0]         cen_run_ff, cen_run_in;
   logic               cen_flag_ff, cen_flag_in;
   logic [3:0]         off_run_ff, off_run_in;
   logic               off_flag_ff, off_flag_in;
   logic               accepted;

   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic               all_near;
   logic [4:0]         cen_inc;
   logic [4:0]         off_inc;

   function automatic logic near_center(input logic [10:0] ch, input logic [10:0] ctr,
                                        input logic [7:0] db);
      logic [10:0] diff;
      diff = (ch >= ctr) ? (ch - ctr) : (ctr - ch);
      return diff <= {3'b000, db};
   endfunction

   // Take a command whenever the response slot is free or draining
   assign pop       = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign all_near = near_center(raw_ff[0], stick_center_ff, deadband_ff)
                  && near_center(raw_ff[1], stick_center_ff, deadband_ff)
                  && near_center(raw_ff[2], stick_center_ff, deadband_ff)
                  && near_center(raw_ff[3], stick_center_ff, deadband_ff);
   assign cen_inc = {1'b0, cen_run_ff} + 5'd1;
   assign off_inc = {1'b0, off_run_ff} + 5'd1;

   // Next state for the command at the queue head
   always_comb begin
      byte_count_in = byte_count_ff;
      raw_in        = raw_ff;
      shown_in      = shown_ff;
      switch_in     = switch_ff;
      word_in       = word_ff;
      cen_run_in    = cen_run_ff;
      cen_flag_in   = cen_flag_ff;
      off_run_in    = off_run_ff;
      off_flag_in   = off_flag_ff;
      accepted      = 1'b0;
      unique case (head.cmd.op)
         OP_BYTE: begin
            if (byte_count_ff < COUNT_W'(BURST_MAX)) begin
               byte_count_in = byte_count_ff + COUNT_W'(1);
            end
         end
         OP_IDLE: begin
            if (byte_count_ff == COUNT_W'(FRAME_BYTES)) begin
               accepted  = 1'b1;
               raw_in[0] = {store_ff[1][2:0], store_ff[0]};
               raw_in[1] = {store_ff[2][5:0], store_ff[1][7:3]};
               raw_in[2] = {store_ff[4][0], store_ff[3], store_ff[2][7:6]};
               raw_in[3] = {store_ff[5][3:0], store_ff[4][7:1]};
               switch_in = store_ff[5][7:4];
               for (int w = 0; w < 6; w++) begin
                  word_in[w] = {store_ff[2*w+7], store_ff[2*w+6]};
               end
               for (int c = 0; c < 4; c++) begin
                  shown_in[c] = cen_flag_ff ? stick_center_ff : raw_in[c];
               end
            end
            byte_count_in = '0;
            off_run_in    = '0;
         end
         OP_TICK: begin
            if (all_near) begin
               if (cen_inc >= {1'b0, settle_count_ff}) begin
                  cen_run_in  = settle_count_ff;
                  cen_flag_in = 1'b1;
               end else begin
                  cen_run_in = cen_inc[3:0];
               end
            end else begin
               cen_run_in  = '0;
               cen_flag_in = 1'b0;
            end
            if (off_inc >= {1'b0, offline_limit_ff}) begin
               off_run_in  = offline_limit_ff;
               off_flag_in = 1'b1;
            end else begin
               off_run_in  = off_inc[3:0];
               off_flag_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Response built from the state after this command
   always_comb begin
      rsp_payload_in.status[ST_ACCEPTED] = accepted;
      rsp_payload_in.status[ST_CENTRED]  = cen_flag_in;
      rsp_payload_in.status[ST_OFFLINE]  = off_flag_in;
      rsp_payload_in.chan_right_h        = shown_in[0];
      rsp_payload_in.chan_right_v        = shown_in[1];
      rsp_payload_in.chan_left_h         = shown_in[2];
      rsp_payload_in.chan_left_v         = shown_in[3];
      rsp_payload_in.switches            = switch_in;
      rsp_payload_in.mouse_dx            = word_in[0];
      rsp_payload_in.mouse_dy            = word_in[1];
      rsp_payload_in.mouse_dz            = word_in[2];
      rsp_payload_in.mouse_buttons       = word_in[3];
      rsp_payload_in.key_bits            = word_in[4];
      rsp_payload_in.wheel               = word_in[5];
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         stick_center_ff  <= STICK_CENTER_RST;
         deadband_ff      <= DEADBAND_RST;
         settle_count_ff  <= SETTLE_COUNT_RST;
         offline_limit_ff <= OFFLINE_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STICK_CENTER:  stick_center_ff  <= csr_wdata[10:0];
            CSR_DEADBAND:      deadband_ff      <= csr_wdata[7:0];
            CSR_SETTLE_COUNT:  settle_count_ff  <= csr_wdata[3:0];
            CSR_OFFLINE_LIMIT: offline_limit_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         raw_ff        <= '{default: '0};
         shown_ff      <= '{default: '0};
         switch_ff     <= '0;
         word_ff       <= '{default: '0};
         cen_run_ff    <= '0;
         cen_flag_ff   <= 1'b0;
         off_run_ff    <= '0;
         off_flag_ff   <= 1'b0;
      end else if (pop) begin
         byte_count_ff <= byte_count_in;
         raw_ff        <= raw_in;
         shown_ff      <= shown_in;
         switch_ff     <= switch_in;
         word_ff       <= word_in;
         cen_run_ff    <= cen_run_in;
         cen_flag_ff   <= cen_flag_in;
         off_run_ff    <= off_run_in;
         off_flag_ff   <= off_flag_in;
      end
   end

   // Frame byte capture, only the first FRAME_BYTES of a burst
   always_ff @(posedge clock) begin
      if (pop && (head.cmd.op == OP_BYTE) && (byte_count_ff < COUNT_W'(FRAME_BYTES))) begin
         store_ff[byte_count_ff[STORE_IDX_W-1:0]] <= head.cmd.data;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

// ===== rtl/rcfd_checker.sv =====
// Port-level checks of the frame decoder and their binding to the top level.
module rcfd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input rcfd_pkg::rsp_payload_type rsp_payload
);
   import rcfd_pkg::*;

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every accepted request is checked for a valid response after the command queue and the response register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("response missing two cycles after request");

   // A frame accepted while centred shows all sticks at the same centre value
   a_centred_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status[ST_ACCEPTED] && rsp_payload.status[ST_CENTRED]
      |-> (rsp_payload.chan_right_h == rsp_payload.chan_right_v)
       && (rsp_payload.chan_right_h == rsp_payload.chan_left_h)
       && (rsp_payload.chan_right_h == rsp_payload.chan_left_v))
      else $error("centred frame shows uneven sticks");

endmodule

bind rc_receiver_frame_decoder_unit rcfd_checker u_rcfd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
